>>> rtl/core/plgm_pkg.sv
// Shared types and constants for the piecewise linear gray map.
// Used by plgm_div_step and piecewise_linear_gray_map; depends on nothing.
package plgm_pkg;

	localparam int GRAY_W              = 8;
	localparam int SLOPE_W             = 9;
	localparam int QUO_W               = 2 * GRAY_W;
	localparam int SUM_W               = QUO_W + 2;
	localparam int DIV_STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES          = QUO_W / DIV_STEPS_PER_STAGE;
	localparam int CFG_IDX_W           = 8;
	localparam int ERR_W               = 2;

	localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

	localparam logic [GRAY_W-1:0] KNEE1_IN_RST  = 8'd50;
	localparam logic [GRAY_W-1:0] KNEE1_OUT_RST = 8'd90;
	localparam logic [GRAY_W-1:0] KNEE2_IN_RST  = 8'd230;
	localparam logic [GRAY_W-1:0] KNEE2_OUT_RST = 8'd215;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KNEE1_IN  = 8'd0,
		REG_KNEE1_OUT = 8'd1,
		REG_KNEE2_IN  = 8'd2,
		REG_KNEE2_OUT = 8'd3
	} cfg_reg_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE        = 2'd0,
		ERR_KNEES_EQUAL = 2'd1,
		ERR_KNEE1_ZERO  = 2'd2,
		ERR_KNEE2_MAX   = 2'd3
	} err_t;

	// Fields that ride alongside the division untouched.
	typedef struct packed {
		logic              neg;
		logic [GRAY_W-1:0] base;
		err_t              err;
	} side_t;

	// One division pipeline slot: partial remainder, dividend/quotient shifter.
	typedef struct packed {
		logic [GRAY_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
		logic [GRAY_W-1:0] den;
		side_t             side;
	} plgm_div_t;

endpackage

>>> rtl/core/piecewise_linear_gray_map.sv
// Top level of the piecewise linear gray map (three-segment contrast stretch).
// Depends on plgm_pkg and plgm_div_step.
//
//   channel   ports                                  transaction when
//   -------   -------------------------------------  -----------------------------
//   pixel in  start, busy, gray_in                   start high, busy low
//   result    done, gray_out, config_error           done high (one cycle, no hold)
//   config    cfg_valid, cfg_ready, cfg_index,       cfg_valid and cfg_ready high
//             cfg_data
//
// One pixel per clock, every clock: busy is never raised and cfg_ready is always high.
// The pipe is the stage 1 and 2 registers, the DIV_STAGES divider slices and the output
// register; the depth is set by the 16-bit restoring divider, 4 quotient bits per slice.
// Reset (arst_n low) loads the default knees and empties the pipe; results in
// flight are dropped. The receiver cannot stall, so nothing ever backs up.
module piecewise_linear_gray_map (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [plgm_pkg::GRAY_W-1:0]       gray_in,
	output logic                              done,
	output logic [plgm_pkg::GRAY_W-1:0]       gray_out,
	output logic [plgm_pkg::ERR_W-1:0]        config_error,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [plgm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [plgm_pkg::GRAY_W-1:0]       cfg_data
);
	import plgm_pkg::*;

	// ---------------------------------------------------------------- config
	logic [GRAY_W-1:0] knee1_in_q, knee1_out_q, knee2_in_q, knee2_out_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knee1_in_q  <= KNEE1_IN_RST;
			knee1_out_q <= KNEE1_OUT_RST;
			knee2_in_q  <= KNEE2_IN_RST;
			knee2_out_q <= KNEE2_OUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KNEE1_IN:  knee1_in_q  <= cfg_data;
				REG_KNEE1_OUT: knee1_out_q <= cfg_data;
				REG_KNEE2_IN:  knee2_in_q  <= cfg_data;
				REG_KNEE2_OUT: knee2_out_q <= cfg_data;
				default: ;  // out-of-range index: write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Pick the segment; everything becomes |diff * slope| / den, signed, plus base.
	// In each chosen segment diff >= 0 and den > 0 (unless a knee error is flagged);
	// only the middle slope can be negative.
	err_t              err_c;
	logic [GRAY_W-1:0] diff_c, mag_c, den_c;
	side_t             side_c;
	logic [SLOPE_W-1:0] slope_c;

	always_comb begin
		priority if (knee1_in_q == knee2_in_q) err_c = ERR_KNEES_EQUAL;
		else if (knee1_in_q == '0)             err_c = ERR_KNEE1_ZERO;
		else if (knee2_in_q == GRAY_MAX)       err_c = ERR_KNEE2_MAX;
		else                                   err_c = ERR_NONE;
	end

	always_comb begin
		priority if (gray_in < knee1_in_q) begin
			diff_c      = gray_in;
			slope_c     = {1'b0, knee1_out_q};
			den_c       = knee1_in_q;
			side_c.base = '0;
		end else if (gray_in <= knee2_in_q) begin
			diff_c      = gray_in - knee1_in_q;
			slope_c     = {1'b0, knee2_out_q} - {1'b0, knee1_out_q};
			den_c       = knee2_in_q - knee1_in_q;
			side_c.base = knee1_out_q;
		end else begin
			// also covers knees out of order: pixels at or above knee 1
			diff_c      = gray_in - knee2_in_q;
			slope_c     = {1'b0, GRAY_MAX} - {1'b0, knee2_out_q};
			den_c       = GRAY_MAX - knee2_in_q;
			side_c.base = knee2_out_q;
		end
		side_c.neg = slope_c[SLOPE_W-1];
		side_c.err = err_c;
		mag_c      = side_c.neg ? GRAY_W'(-slope_c) : slope_c[GRAY_W-1:0];
	end

	logic              valid_s1;
	logic [GRAY_W-1:0] diff_s1, mag_s1, den_s1;
	side_t             side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff_c;
		mag_s1  <= mag_c;
		den_s1  <= den_c;
		side_s1 <= side_c;
	end

	// ---------------------------------------------------------------- stage 2
	// 8x8 unsigned product, at most 255*255, then straight into the divider.
	logic      valid_s2;
	plgm_div_t div_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		div_s2.rem  <= '0;
		div_s2.quo  <= QUO_W'(diff_s1) * QUO_W'(mag_s1);
		div_s2.den  <= den_s1;
		div_s2.side <= side_s1;
	end

	// ---------------------------------------------------------------- divider
	// Magnitude division truncates toward zero once the sign goes back on.
	logic      div_valid [DIV_STAGES+1];
	plgm_div_t div_data  [DIV_STAGES+1];

	assign div_valid[0] = valid_s2;
	assign div_data[0]  = div_s2;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		plgm_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[k]),
			.in_data   (div_data[k]),
			.out_valid (div_valid[k+1]),
			.out_data  (div_data[k+1])
		);
	end

	// ---------------------------------------------------------------- output
	// Restore sign, add the segment base, clamp to 0..255; zero on a knee error.
	plgm_div_t         div_last;
	logic [SUM_W-1:0]  quo_ext, base_ext, sum_c;
	logic [GRAY_W-1:0] gray_c;

	assign div_last = div_data[DIV_STAGES];
	assign quo_ext  = {2'b00, div_last.quo};
	assign base_ext = {{(SUM_W-GRAY_W){1'b0}}, div_last.side.base};
	assign sum_c    = div_last.side.neg ? base_ext - quo_ext : base_ext + quo_ext;

	always_comb begin
		priority if (div_last.side.err != ERR_NONE) gray_c = '0;
		else if (sum_c[SUM_W-1])                     gray_c = '0;
		else if (sum_c[SUM_W-2:GRAY_W] != '0)       gray_c = GRAY_MAX;
		else                                         gray_c = sum_c[GRAY_W-1:0];
	end

	logic              done_q;
	logic [GRAY_W-1:0] gray_out_q;
	err_t              config_error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		gray_out_q     <= gray_c;
		config_error_q <= div_last.side.err;
	end

	assign done         = done_q;
	assign gray_out     = gray_out_q;
	assign config_error = config_error_q;

	// ---------------------------------------------------------------- checks
	localparam int LATENCY = DIV_STAGES + 3;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted pixel did not produce a result on time");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && config_error != ERR_NONE) |-> (gray_out == '0))
		else $error("nonzero pixel reported with a knee error");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && side_s1.err == ERR_NONE) |-> (den_s1 != '0))
		else $error("zero divisor on a valid knee setting");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(valid_s2, DIV_STAGES + 1))
		else $error("result strobe without a matching pixel");

endmodule

>>> rtl/core/plgm_div_step.sv
// One registered slice of the restoring divider: DIV_STEPS_PER_STAGE quotient bits.
// Depends on plgm_pkg.
module plgm_div_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  plgm_pkg::plgm_div_t in_data,
	output logic                out_valid,
	output plgm_pkg::plgm_div_t out_data
);
	import plgm_pkg::*;

	plgm_div_t nxt;
	logic      valid_q;
	plgm_div_t data_q;

	always_comb begin
		logic [GRAY_W:0] trial;
		nxt = in_data;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			trial   = {nxt.rem, nxt.quo[QUO_W-1]};
			nxt.quo = {nxt.quo[QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, nxt.den}) begin
				trial      = trial - {1'b0, nxt.den};
				nxt.quo[0] = 1'b1;
			end
			nxt.rem = trial[GRAY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
